// ===== rtl/dtv_pkg.sv =====
package dtv_pkg;

  localparam int unsigned FormLen  = 10;
  localparam int unsigned PosSat   = 11;

  localparam logic [3:0] POS_SLASH_A = 4'd2;
  localparam logic [3:0] POS_SLASH_B = 4'd5;
  localparam logic [3:0] POS_DAY     = 4'd3;
  localparam logic [3:0] POS_YEAR    = 4'd6;
  localparam logic [3:0] POS_YEAR_LO = 4'd8;
  localparam logic [3:0] POS_LAST    = 4'(FormLen - 1);
  localparam logic [3:0] POS_END     = 4'(FormLen);
  localparam logic [3:0] POS_SAT     = 4'(PosSat);

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SYNTAX = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [13:0] year;
  } res_t;

  // Days in month m (1..12); leap selects 29 for February.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/dtv_if.sv =====
interface dtv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source(output valid, output in_byte, output last_byte, input ready);
  modport sink(input valid, input in_byte, input last_byte, output ready);
endinterface

interface dtv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [13:0] year_out;

  modport source(output valid, output status, output month_out, output day_out,
                 output year_out, input ready);
  modport sink(input valid, input status, input month_out, input day_out,
               input year_out, output ready);
endinterface

// ===== rtl/dtv_core.sv =====
// Per-string parse state and final check; state advances on step.
module dtv_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        byte_in,
  input  logic              last_in,
  output dtv_pkg::res_t     res
);

  logic [3:0]  pos_r;
  logic        bad_r, bad_nxt;
  logic [6:0]  mon_r, mon_nxt;
  logic [6:0]  day_r, day_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  pair_r, pair_nxt;     // current two-digit group of the year
  logic [1:0]  hi_mod4_r, hi_mod4_nxt; // century digits mod 4
  logic [3:0]  pos_nxt;

  logic        is_dig;
  logic [3:0]  dig;
  logic        bad_fin;
  logic        leap;
  logic [4:0]  mlen;
  logic        range_bad;

  assign is_dig = (byte_in >= dtv_pkg::CH_ZERO) && (byte_in <= dtv_pkg::CH_NINE);
  assign dig    = byte_in[3:0];

  always_comb begin
    bad_nxt     = bad_r;
    mon_nxt     = mon_r;
    day_nxt     = day_r;
    year_nxt    = year_r;
    pair_nxt    = pair_r;
    hi_mod4_nxt = hi_mod4_r;
    if (pos_r >= dtv_pkg::POS_END) begin
      bad_nxt = 1'b1;
    end else if (pos_r == dtv_pkg::POS_SLASH_A || pos_r == dtv_pkg::POS_SLASH_B) begin
      if (byte_in != dtv_pkg::CH_SLASH) bad_nxt = 1'b1;
    end else if (is_dig) begin
      if (pos_r < dtv_pkg::POS_SLASH_A) begin
        mon_nxt = mon_r * 7'd10 + {3'b000, dig};
      end else if (pos_r < dtv_pkg::POS_SLASH_B) begin
        day_nxt = day_r * 7'd10 + {3'b000, dig};
      end else begin
        year_nxt = year_r * 14'd10 + {10'd0, dig};
        if (pos_r == dtv_pkg::POS_YEAR || pos_r == dtv_pkg::POS_YEAR_LO) begin
          pair_nxt = {3'b000, dig};
        end else begin
          pair_nxt = pair_r * 7'd10 + {3'b000, dig};
        end
        if (pos_r == dtv_pkg::POS_YEAR_LO) hi_mod4_nxt = pair_r[1:0];
      end
    end else begin
      bad_nxt = 1'b1;
    end
  end

  assign pos_nxt = (pos_r < dtv_pkg::POS_SAT) ? pos_r + 4'd1 : dtv_pkg::POS_SAT;

  // Only meaningful for a well-formed string: year is exactly four digits.
  assign bad_fin   = bad_nxt || (pos_r != dtv_pkg::POS_LAST);
  assign leap      = (pair_nxt[1:0] == 2'b00) &&
                     ((pair_nxt != 7'd0) || (hi_mod4_r == 2'b00));
  assign mlen      = dtv_pkg::month_days(mon_nxt[3:0], leap);
  assign range_bad = (mon_nxt < 7'd1) || (mon_nxt > 7'd12) || (year_nxt == 14'd0) ||
                     (day_nxt == 7'd0) || (day_nxt > {2'b00, mlen});

  always_comb begin
    res = '0;
    if (bad_fin) begin
      res.status = dtv_pkg::ST_SYNTAX;
    end else if (range_bad) begin
      res.status = dtv_pkg::ST_RANGE;
    end else begin
      res.status = dtv_pkg::ST_OK;
      res.month  = mon_nxt[3:0];
      res.day    = day_nxt[4:0];
      res.year   = year_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_in)) begin
      pos_r     <= '0;
      bad_r     <= 1'b0;
      mon_r     <= '0;
      day_r     <= '0;
      year_r    <= '0;
      pair_r    <= '0;
      hi_mod4_r <= '0;
    end else if (step) begin
      pos_r     <= pos_nxt;
      bad_r     <= bad_nxt;
      mon_r     <= mon_nxt;
      day_r     <= day_nxt;
      year_r    <= year_nxt;
      pair_r    <= pair_nxt;
      hi_mod4_r <= hi_mod4_nxt;
    end
  end

endmodule

// ===== rtl/date_text_validator.sv =====
// MM/DD/YYYY date text validator.
// in_ch : one ASCII character per transfer, last_byte set on the final one.
// out_ch: one result per string, on the transfer carrying last_byte:
//         status (0 ok, 1 syntax, 2 out of range) plus month/day/year,
//         the value fields zero unless status is ok.
// Both channels are valid/ready; a transfer happens when both are high.
// Throughput: one character per cycle, no gaps between strings, unless a held result stalls a last character.
// Path: characters land in an input register; the parse state updates
//   from it, and for the last character the result register loads at
//   that same edge, so out_ch.valid rises when the last character
//   leaves the input register.
// Stall: a held result blocks only the next last character; ordinary
//   characters keep flowing into the parse state while out_ch waits.
// Reset (rst_n low, synchronous): input and result registers empty, parse
//   state cleared, ready to take the first character of a new string.
// Parse state is also cleared after every last character.
module date_text_validator (
  input  logic              clk,
  input  logic              rst_n,
  dtv_in_if.sink            in_ch,
  dtv_out_if.source         out_ch
);

  // input register
  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;
  logic          s1_last_r;

  // result register
  logic          out_valid_r;
  dtv_pkg::res_t out_res_r;

  dtv_pkg::res_t res;
  logic          adv;
  logic          in_xfer;

  // A non-final character never needs the result register.
  assign adv     = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_xfer = in_ch.valid && in_ch.ready;

  dtv_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .byte_in (s1_byte_r),
    .last_in (s1_last_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_ch.in_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_res_r.status;
  assign out_ch.month_out = out_res_r.month;
  assign out_ch.day_out   = out_res_r.day;
  assign out_ch.year_out  = out_res_r.year;

  // Error results never carry a value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status != dtv_pkg::ST_OK) |->
      (out_res_r.month == 4'd0) && (out_res_r.day == 5'd0) && (out_res_r.year == 14'd0))
    else $error("error result with nonzero value");

  // A good result holds a real month and day.
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status == dtv_pkg::ST_OK) |->
      (out_res_r.month >= 4'd1) && (out_res_r.month <= 4'd12) &&
      (out_res_r.day != 5'd0) && (out_res_r.year != 14'd0))
    else $error("ok result out of range");

  // A non-final character in the input register always moves on.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_last_r |-> adv && in_ch.ready)
    else $error("non-final character stalled");

  // A result only loads from a final character.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(out_valid_r) && out_valid_r |-> $past(adv && s1_last_r))
    else $error("result without final character");

endmodule
